// ===== src/cah_pkg.sv =====
`default_nettype none

package cah_pkg;

  // Default widths of the sample path and of the internal accumulators.
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int ACC_WIDTH_DEF    = 32;

  // Gains are Q0.24 and carried in 25 bits, so that 1.0 is representable.
  localparam int GAIN_W = 25;

  // Multiplier operand width for gains: a Q0.24 gain or tightness, signed.
  localparam int MUL_B_W = GAIN_W + 1;

  // Fixed point constants of the gain path.
  localparam int ONE_INT         = 16777216;  // 1.0 in Q0.24
  localparam int MIN_GAIN_INT    = 2;         // 1e-7 in Q0.24, rounded
  localparam int TIGHT_LIM_INT   = 8388608;   // 1.0 in Q1.23
  localparam int DEPTH_RESET_INT = 4194304;   // 1.0 in Q2.22

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_AMOUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIGHTNESS     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STAGE_DEPTH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WET_MIX       = 3'd3;

  // Settings shared by every stage cell while one sample is processed.
  typedef struct packed {
    logic              bank;
    logic [GAIN_W-1:0] coef;
  } cah_ctrl_t;

endpackage

`default_nettype wire

// ===== src/cah_sat.sv =====
`default_nettype none

module cah_sat #(
  parameter int IW = 34,
  parameter int OW = 32
) (
  input  wire logic signed [IW-1:0] din,
  output logic signed [OW-1:0]      dout
);

  logic [IW-OW:0] top_bits;

  assign top_bits = din[IW-1:OW-1];

  // The value fits when all bits above the output sign agree with it.
  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      dout = din[OW-1:0];
    end else if (din[IW-1]) begin
      dout = {1'b1, {(OW-1){1'b0}}};
    end else begin
      dout = {1'b0, {(OW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ===== src/cah_mul.sv =====
`default_nettype none

module cah_mul #(
  parameter int AW = 33
) (
  input  wire logic                               clk,
  input  wire logic signed [AW-1:0]               a,
  input  wire logic signed [cah_pkg::MUL_B_W-1:0] b,
  output logic signed [AW:0]                      res
);

  localparam int HW = AW - 24;
  localparam int LW = 24;
  localparam int PLW = LW + 1 + cah_pkg::MUL_B_W;

  logic signed [HW-1:0]                     a_hi;
  logic [LW-1:0]                            a_lo;
  logic signed [HW+cah_pkg::MUL_B_W-1:0]    p_hi;
  logic signed [PLW-1:0]                    p_lo;
  logic signed [PLW-LW-1:0]                 lo_shift;
  logic signed [AW+1:0]                     sum;

  // Split a into floor(a / 2^24) and the non-negative remainder so that
  // each partial product stays narrow.
  assign a_hi = a[AW-1:LW];
  assign a_lo = a[LW-1:0];

  // Partial products are registered.
  always_ff @(posedge clk) begin
    p_hi <= a_hi * b;
    p_lo <= $signed({1'b0, a_lo}) * b;
  end

  // floor(a * b / 2^24) = hi * b + floor(lo * b / 2^24).
  assign lo_shift = p_lo[PLW-1:LW];
  assign sum      = p_hi + lo_shift;
  assign res      = sum[AW:0];

endmodule

`default_nettype wire

// ===== src/cah_cell.sv =====
`default_nettype none

module cah_cell #(
  parameter int ACC_WIDTH = cah_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [ACC_WIDTH-1:0]       y_in,
  input  wire cah_pkg::cah_ctrl_t                ctrl,
  input  wire logic [cah_pkg::GAIN_W-1:0]        weight,
  output logic                                   done,
  output logic signed [ACC_WIDTH-1:0]            y_out
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_MEM  = 2'd1;
  localparam logic [1:0] C_PROD = 2'd2;
  localparam logic [1:0] C_YUPD = 2'd3;

  logic [1:0]                          state;
  logic signed [ACC_WIDTH-1:0]         mem [2];
  logic signed [ACC_WIDTH-1:0]         m_cur;
  logic signed [ACC_WIDTH-1:0]         y_reg;
  logic signed [ACC_WIDTH:0]           mul_a;
  logic signed [cah_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [ACC_WIDTH+1:0]         mul_res;
  logic signed [ACC_WIDTH+2:0]         mem_sum;
  logic signed [ACC_WIDTH+2:0]         y_sum;
  logic signed [ACC_WIDTH-1:0]         mem_sat;
  logic signed [ACC_WIDTH-1:0]         y_sat;

  // First product is (y - m) * g, taken as the sample enters; the second is m * w.
  always_comb begin
    if (state == C_PROD) begin
      mul_a = m_cur;
      mul_b = $signed({1'b0, weight});
    end else begin
      mul_a = y_in - mem[ctrl.bank];
      mul_b = $signed({1'b0, ctrl.coef});
    end
  end

  cah_mul #(.AW(ACC_WIDTH + 1)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  // Memory update and signal update, both saturated.
  assign mem_sum = m_cur + mul_res;
  assign y_sum   = y_reg - mul_res;

  cah_sat #(.IW(ACC_WIDTH + 3), .OW(ACC_WIDTH)) u_sat_mem (
    .din  (mem_sum),
    .dout (mem_sat)
  );

  cah_sat #(.IW(ACC_WIDTH + 3), .OW(ACC_WIDTH)) u_sat_y (
    .din  (y_sum),
    .dout (y_sat)
  );

  // Sequencer and stage memory of both banks.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= C_IDLE;
      done   <= 1'b0;
      mem[0] <= '0;
      mem[1] <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            if (weight == '0) begin
              done <= 1'b1;
            end else begin
              state <= C_MEM;
            end
          end
        end
        C_MEM: begin
          mem[ctrl.bank] <= mem_sat;
          state          <= C_PROD;
        end
        C_PROD: begin
          state <= C_YUPD;
        end
        C_YUPD: begin
          done  <= 1'b1;
          state <= C_IDLE;
        end
      endcase
    end
  end

  // Working copies of the signal and of the selected memory.
  always_ff @(posedge clk) begin
    if (state == C_IDLE && start) begin
      y_reg <= y_in;
      m_cur <= mem[ctrl.bank];
    end else if (state == C_MEM) begin
      m_cur <= mem_sat;
    end else if (state == C_YUPD) begin
      y_reg <= y_sat;
    end
  end

  assign y_out = y_reg;

endmodule

`default_nettype wire

// ===== src/cascaded_adaptive_highpass.sv =====
`default_nettype none
// Each accepted sample runs through all four stage cells; a stage whose weight is zero
// is bypassed and skips its update, and a wet mix of 1.0 skips the mix step.
// A new sample is taken only once the last result is loaded; the stage cells work one after
// another on the same sample, each with its own multiplier used twice.
// Reset: stage memories clear, the first bank is used, registers take their defaults.

module cascaded_adaptive_highpass #(
  parameter int SAMPLE_WIDTH = cah_pkg::SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = cah_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_in,
  input  wire logic                                block_end_in,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]           sample_out,
  output logic                                     block_end_out,
  input  wire logic                                cfg_write,
  input  wire logic [cah_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [cah_pkg::GAIN_W-1:0]          cfg_data
);

  localparam int GW    = cah_pkg::GAIN_W;
  localparam int GUARD = (ACC_WIDTH - SAMPLE_WIDTH - 4 > 0) ?
                         (ACC_WIDTH - SAMPLE_WIDTH - 4) : 0;
  localparam int DW    = ((SAMPLE_WIDTH + GUARD > ACC_WIDTH) ?
                          (SAMPLE_WIDTH + GUARD) : ACC_WIDTH) + 1;
  localparam int TW    = (ACC_WIDTH + 1 > cah_pkg::MUL_B_W) ?
                         (ACC_WIDTH + 1) : cah_pkg::MUL_B_W;
  localparam int EW    = ((ACC_WIDTH > SAMPLE_WIDTH) ? ACC_WIDTH : SAMPLE_WIDTH) + 1;
  localparam int NCELL = 4;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_OFFS_GO = 4'd1;
  localparam logic [3:0] S_OFFS    = 4'd2;
  localparam logic [3:0] S_GAIN_GO = 4'd3;
  localparam logic [3:0] S_GAIN    = 4'd4;
  localparam logic [3:0] S_CELLS   = 4'd5;
  localparam logic [3:0] S_MIX_GO  = 4'd6;
  localparam logic [3:0] S_MIX     = 4'd7;
  localparam logic [3:0] S_OUT     = 4'd8;

  logic [3:0]                          state;
  logic                                start_r;
  logic                                bank_select;
  logic                                accept;
  logic                                load;

  // Configuration, stored already clamped.
  logic [GW-1:0]                       amount_q;
  logic signed [GW:0]                  t24_q;
  logic [GW-1:0]                       depth_q;
  logic [GW-1:0]                       wet_q;
  logic [GW-1:0]                       amount_c;
  logic signed [GW:0]                  t24_c;
  logic signed [GW-1:0]                tight_s;
  logic [GW-1:0]                       depth_c;
  logic [GW-1:0]                       wet_c;
  logic                                wet_one;
  logic                                t_pos;

  // Sample front end.
  logic [SAMPLE_WIDTH-1:0]             abs_x;
  logic [SAMPLE_WIDTH+GW-1:0]          mag_wide;
  logic [GW-1:0]                       mag_reg;
  logic [GW-1:0]                       mag_sel;
  logic signed [DW-1:0]                x_ext;
  logic signed [DW-1:0]                x_shift;
  logic signed [ACC_WIDTH-1:0]         dry_sat;
  logic signed [ACC_WIDTH-1:0]         dry_reg;
  logic                                blk_reg;

  // Gain path.
  logic signed [TW-1:0]                mul_a;
  logic signed [cah_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [TW:0]                  mul_res;
  logic signed [27:0]                  off_base;
  logic signed [27:0]                  off_sum;
  logic [GW-1:0]                       off_reg;
  logic [GW-1:0]                       g_reg;

  // Stage weights.
  logic [1:0]                          seg;
  logic [GW-1:0]                       seg_frac;
  logic [GW-1:0]                       weight [NCELL];

  // Cell chain.
  logic signed [ACC_WIDTH-1:0]         y_link [NCELL+1];
  logic [NCELL:0]                      done_link;
  cah_pkg::cah_ctrl_t                  cell_ctrl;

  // Mix and output.
  logic signed [ACC_WIDTH:0]           mix_diff;
  logic signed [TW+1:0]                mix_sum;
  logic signed [ACC_WIDTH-1:0]         mix_sat;
  logic signed [ACC_WIDTH-1:0]         y_fin;
  logic signed [ACC_WIDTH-1:0]         y_shift;
  logic signed [EW-1:0]                y_ext;
  logic signed [SAMPLE_WIDTH-1:0]      out_sat;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load     = (state == S_OUT) && (!out_valid || !out_stall);

  // Clamp incoming register values; a positive tightness doubles into Q0.24.
  assign tight_s = $signed(cfg_data);

  always_comb begin
    if (cfg_data < GW'(cah_pkg::MIN_GAIN_INT)) begin
      amount_c = GW'(cah_pkg::MIN_GAIN_INT);
    end else if (cfg_data > GW'(cah_pkg::ONE_INT)) begin
      amount_c = GW'(cah_pkg::ONE_INT);
    end else begin
      amount_c = cfg_data;
    end

    if (tight_s > cah_pkg::TIGHT_LIM_INT) begin
      t24_c = (GW+1)'(cah_pkg::ONE_INT);
    end else if (tight_s > 0) begin
      t24_c = $signed({tight_s, 1'b0});
    end else if (tight_s < -cah_pkg::TIGHT_LIM_INT) begin
      t24_c = -(GW+1)'(cah_pkg::TIGHT_LIM_INT);
    end else begin
      t24_c = tight_s;
    end

    depth_c = (cfg_data > GW'(cah_pkg::ONE_INT)) ? GW'(cah_pkg::ONE_INT) : cfg_data;
    wet_c   = (cfg_data > GW'(cah_pkg::ONE_INT)) ? GW'(cah_pkg::ONE_INT) : cfg_data;
  end

  assign wet_one = (wet_q == GW'(cah_pkg::ONE_INT));
  assign t_pos   = (t24_q > 0);

  // Stage weights: stages below the depth segment are full, the segment's stage fades.
  assign seg      = depth_q[GW-1] ? 2'd3 : depth_q[GW-2:GW-3];
  assign seg_frac = depth_q[GW-1] ? GW'(cah_pkg::ONE_INT) : {1'b0, depth_q[GW-4:0], 2'b00};

  always_comb begin
    for (int i = 0; i < NCELL; i++) begin
      if (2'(i) < seg) begin
        weight[i] = GW'(cah_pkg::ONE_INT);
      end else if (2'(i) == seg) begin
        weight[i] = seg_frac;
      end else begin
        weight[i] = '0;
      end
    end
  end

  // Sample magnitude in Q0.24 and the dry signal with guard bits.
  assign abs_x    = sample_in[SAMPLE_WIDTH-1] ? -sample_in : sample_in;
  assign mag_wide = {abs_x, {GW{1'b0}}} >> SAMPLE_WIDTH;
  assign x_ext    = sample_in;
  assign x_shift  = x_ext <<< GUARD;

  cah_sat #(.IW(DW), .OW(ACC_WIDTH)) u_sat_dry (
    .din  (x_shift),
    .dout (dry_sat)
  );

  // Shared multiplier of the coefficient and mix path.
  assign mag_sel  = t_pos ? mag_reg : GW'(cah_pkg::ONE_INT) - mag_reg;
  assign mix_diff = y_link[NCELL] - dry_reg;

  always_comb begin
    unique case (state)
      S_GAIN_GO: begin
        mul_a = {{(TW-GW){1'b0}}, off_reg};
        mul_b = $signed({1'b0, amount_q});
      end
      S_MIX_GO: begin
        mul_a = mix_diff;
        mul_b = $signed({1'b0, wet_q});
      end
      default: begin
        mul_a = {{(TW-GW){1'b0}}, mag_sel};
        mul_b = t24_q;
      end
    endcase
  end

  cah_mul #(.AW(TW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  // Offset before clamping.
  assign off_base = t_pos ? 28'sd16777216 - t24_q : 28'sd16777216 + t24_q;
  assign off_sum  = off_base + 28'(mul_res);

  // Stage cells in a chain; each hands its signal and done flag to the next.
  assign cell_ctrl    = '{bank: ~bank_select, coef: g_reg};
  assign y_link[0]    = dry_reg;
  assign done_link[0] = start_r;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cah_cell #(.ACC_WIDTH(ACC_WIDTH)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .start  (done_link[i]),
      .y_in   (y_link[i]),
      .ctrl   (cell_ctrl),
      .weight (weight[i]),
      .done   (done_link[i+1]),
      .y_out  (y_link[i+1])
    );
  end

  // Wet/dry blend.
  assign mix_sum = dry_reg + mul_res;

  cah_sat #(.IW(TW + 2), .OW(ACC_WIDTH)) u_sat_mix (
    .din  (mix_sum),
    .dout (mix_sat)
  );

  // Remove the guard bits and saturate to the sample width.
  assign y_shift = y_fin >>> GUARD;
  assign y_ext   = y_shift;

  cah_sat #(.IW(EW), .OW(SAMPLE_WIDTH)) u_sat_out (
    .din  (y_ext),
    .dout (out_sat)
  );

  // Control: sequencer, bank select, output valid and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      start_r     <= 1'b0;
      bank_select <= 1'b1;
      out_valid   <= 1'b0;
      amount_q    <= GW'(cah_pkg::ONE_INT);
      t24_q       <= '0;
      depth_q     <= GW'(cah_pkg::DEPTH_RESET_INT);
      wet_q       <= GW'(cah_pkg::ONE_INT);
    end else begin
      start_r <= 1'b0;

      if (cfg_write) begin
        if (cfg_index == cah_pkg::REG_FILTER_AMOUNT) begin
          amount_q <= amount_c;
        end
        if (cfg_index == cah_pkg::REG_TIGHTNESS) begin
          t24_q <= t24_c;
        end
        if (cfg_index == cah_pkg::REG_STAGE_DEPTH) begin
          depth_q <= depth_c;
        end
        if (cfg_index == cah_pkg::REG_WET_MIX) begin
          wet_q <= wet_c;
        end
      end

      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_OFFS_GO;
          end
        end
        S_OFFS_GO: state <= S_OFFS;
        S_OFFS:    state <= S_GAIN_GO;
        S_GAIN_GO: state <= S_GAIN;
        S_GAIN: begin
          start_r <= 1'b1;
          state   <= S_CELLS;
        end
        S_CELLS: begin
          if (done_link[NCELL]) begin
            state <= wet_one ? S_OUT : S_MIX_GO;
          end
        end
        S_MIX_GO:  state <= S_MIX;
        S_MIX:     state <= S_OUT;
        S_OUT: begin
          if (load) begin
            bank_select <= ~bank_select;
            state       <= S_IDLE;
          end
        end
        default:   state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      mag_reg <= mag_wide[GW-1:0];
      dry_reg <= dry_sat;
      blk_reg <= block_end_in;
    end
    if (state == S_OFFS) begin
      if (off_sum < cah_pkg::MIN_GAIN_INT) begin
        off_reg <= GW'(cah_pkg::MIN_GAIN_INT);
      end else if (off_sum > cah_pkg::ONE_INT) begin
        off_reg <= GW'(cah_pkg::ONE_INT);
      end else begin
        off_reg <= off_sum[GW-1:0];
      end
    end
    if (state == S_GAIN) begin
      g_reg <= mul_res[GW-1:0];
    end
    if (state == S_CELLS && done_link[NCELL]) begin
      y_fin <= y_link[NCELL];
    end else if (state == S_MIX) begin
      y_fin <= mix_sat;
    end
    if (load) begin
      sample_out    <= out_sat;
      block_end_out <= blk_reg;
    end
  end

  // The last cell finishes only while the sequencer waits for it.
  a_done_in_cells: assert property (@(posedge clk) disable iff (rst)
    done_link[NCELL] |-> state == S_CELLS)
    else $error("stage chain finished outside the cell phase");

  // Only one cell of the chain hands on a sample at a time.
  a_one_cell: assert property (@(posedge clk) disable iff (rst)
    $onehot0(done_link))
    else $error("more than one cell active in the chain");

  // Every delivered result switches the memory bank.
  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid && (bank_select != $past(bank_select)))
    else $error("result loaded without a bank switch");

  // The chain is started only on entry to the cell phase.
  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    start_r |-> state == S_CELLS && $past(state) == S_GAIN)
    else $error("stage chain started out of sequence");

endmodule

`default_nettype wire

// ===== sim/cah_highpass_checker.sv =====
`timescale 1ns / 1ps

module cah_highpass_checker #(
  parameter int SAMPLE_WIDTH = cah_pkg::SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = cah_pkg::ACC_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
  input  logic                              block_end_in,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_out,
  input  logic                              block_end_out,
  input  logic                              cfg_write,
  input  logic [cah_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cah_pkg::GAIN_W-1:0]        cfg_data,
  output int                                mismatches,
  output int                                outstanding
);
  import cah_pkg::*;

  // The signal path carries the sample with a few guard bits below it.
  localparam int GUARD = (ACC_WIDTH - SAMPLE_WIDTH - 4 > 0) ? ACC_WIDTH - SAMPLE_WIDTH - 4 : 0;
  localparam int FRAC = SAMPLE_WIDTH - 1;
  localparam int MAG_UP = (FRAC <= 24) ? 24 - FRAC : 0;
  localparam int MAG_DOWN = (FRAC > 24) ? FRAC - 24 : 0;
  localparam longint ONE = ONE_INT;
  localparam longint DEPTH_UNIT = longint'(1) <<< 22;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           block_end;
  } filtered_t;

  filtered_t         expected_samples[$];
  filtered_t         oldest;
  longint            stage_mem [8];
  logic              use_first_bank;
  logic [GAIN_W-1:0] amount_reg;
  logic [GAIN_W-1:0] tight_reg;
  logic [GAIN_W-1:0] depth_reg;
  logic [GAIN_W-1:0] wet_reg;
  int                new_errors;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint saturate(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    return clip(v, -hi - 1, hi);
  endfunction

  // Product with a Q0.24 gain, rounded toward minus infinity.
  function automatic longint scale_q24(longint a, longint b);
    return (a * b) >>> 24;
  endfunction

  // Runs one sample through the cascade and advances the stage memories.
  function automatic filtered_t filter_sample(logic signed [SAMPLE_WIDTH-1:0] x_in, logic be);
    longint    x;
    longint    amount;
    longint    tight;
    longint    depth;
    longint    wet;
    longint    t24;
    longint    mag;
    longint    offset;
    longint    g;
    longint    dry;
    longint    y;
    longint    r;
    longint    weight [4];
    int        bank;
    int        idx;
    filtered_t res;
    x      = x_in;
    amount = clip(longint'(amount_reg), MIN_GAIN_INT, ONE);
    tight  = clip(longint'($signed(tight_reg)), -TIGHT_LIM_INT, TIGHT_LIM_INT);
    depth  = clip(longint'(depth_reg), 0, 4 * DEPTH_UNIT);
    wet    = clip(longint'(wet_reg), 0, ONE);

    // Positive tightness moves to Q0.24; a halved negative one keeps its integer.
    t24 = (tight > 0) ? tight * 2 : tight;
    mag = (x < 0) ? -x : x;
    mag = (mag <<< MAG_UP) >>> MAG_DOWN;
    if (t24 > 0) begin
      offset = (ONE - t24) + scale_q24(mag, t24);
    end else begin
      offset = (ONE + t24) + scale_q24(ONE - mag, t24);
    end
    offset = clip(offset, MIN_GAIN_INT, ONE);
    g = scale_q24(offset, amount);

    // Stages fade in one after another as the depth rises.
    for (int s = 0; s < 4; s++) weight[s] = ONE;
    if (depth < DEPTH_UNIT) begin
      weight[0] = depth * 4;
      weight[1] = 0;
      weight[2] = 0;
      weight[3] = 0;
    end else if (depth < 2 * DEPTH_UNIT) begin
      weight[1] = (depth - DEPTH_UNIT) * 4;
      weight[2] = 0;
      weight[3] = 0;
    end else if (depth < 3 * DEPTH_UNIT) begin
      weight[2] = (depth - 2 * DEPTH_UNIT) * 4;
      weight[3] = 0;
    end else begin
      weight[3] = (depth - 3 * DEPTH_UNIT) * 4;
    end

    // Bypassed stages leave their memory untouched.
    dry  = saturate(x <<< GUARD, ACC_WIDTH);
    y    = dry;
    bank = use_first_bank ? 0 : 1;
    for (int s = 0; s < 4; s++) begin
      idx = 2 * s + bank;
      if (weight[s] > 0) begin
        stage_mem[idx] = saturate(stage_mem[idx] + scale_q24(y - stage_mem[idx], g), ACC_WIDTH);
        y = saturate(y - scale_q24(stage_mem[idx], weight[s]), ACC_WIDTH);
      end
    end
    if (wet != ONE) begin
      y = saturate(dry + scale_q24(y - dry, wet), ACC_WIDTH);
    end
    use_first_bank = !use_first_bank;

    r = saturate(y >>> GUARD, SAMPLE_WIDTH);
    res.sample    = r[SAMPLE_WIDTH-1:0];
    res.block_end = be;
    return res;
  endfunction

  // Compare each result transaction, track register writes, predict each input.
  always @(posedge clk) begin
    new_errors = 0;
    if (rst) begin
      expected_samples.delete();
      for (int i = 0; i < 8; i++) stage_mem[i] = 0;
      use_first_bank = 1'b1;
      amount_reg = ONE_INT;
      tight_reg = '0;
      depth_reg = DEPTH_RESET_INT;
      wet_reg = ONE_INT;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, actual sample %0d end %0b",
                   $time, sample_out, block_end_out);
          new_errors++;
        end else begin
          oldest = expected_samples.pop_front();
          if (sample_out !== oldest.sample) begin
            $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                     $time, oldest.sample, sample_out);
            new_errors++;
          end
          if (block_end_out !== oldest.block_end) begin
            $display("%0t: block_end_out mismatch: expected %0b, actual %0b",
                     $time, oldest.block_end, block_end_out);
            new_errors++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_FILTER_AMOUNT: amount_reg = cfg_data;
          REG_TIGHTNESS:     tight_reg = cfg_data;
          REG_STAGE_DEPTH:   depth_reg = cfg_data;
          REG_WET_MIX:       wet_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_samples.push_back(filter_sample(sample_in, block_end_in));
      end
    end
    mismatches <= mismatches + new_errors;
    outstanding <= expected_samples.size();
  end

endmodule

// ===== sim/tb_cascaded_adaptive_highpass.sv =====
`timescale 1ns / 1ps

module tb_cascaded_adaptive_highpass;
  import cah_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int AW = ACC_WIDTH_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 500;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd5;
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW - 1){1'b0}}};

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [SW-1:0]    sample_in = '0;
  logic                    block_end_in = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SW-1:0]    sample_out;
  logic                    block_end_out;
  logic                    cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [GAIN_W-1:0]       cfg_data = '0;
  int                      mismatches;
  int                      outstanding;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  // Directed corner values and register presets.
  logic signed [SW-1:0] corner_samples [9] = '{0, SAMPLE_MAX, SAMPLE_MIN, -1, 1,
                                               SAMPLE_MAX, SAMPLE_MIN, 4096, -4096};
  logic [GAIN_W-1:0] preset_amount [5] = '{ONE_INT, 0, GAIN_MAX, 8388608, 12345};
  logic [GAIN_W-1:0] preset_tight [5] = '{25'h0800000, 25'h1800000, GAIN_MAX,
                                          25'h1000000, 25'h0FFFFFF};
  logic [GAIN_W-1:0] preset_depth [5] = '{ONE_INT, 0, GAIN_MAX, 14680064, 10485760};
  logic [GAIN_W-1:0] preset_wet [5] = '{ONE_INT, 0, GAIN_MAX, 8388608, ONE_INT - 1};

  always #5 clk = ~clk;

  cascaded_adaptive_highpass #(
    .SAMPLE_WIDTH(SW),
    .ACC_WIDTH(AW)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_in(sample_in),
    .block_end_in(block_end_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_out(sample_out),
    .block_end_out(block_end_out),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cah_highpass_checker #(
    .SAMPLE_WIDTH(SW),
    .ACC_WIDTH(AW)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_in(sample_in),
    .block_end_in(block_end_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_out(sample_out),
    .block_end_out(block_end_out),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  // The result side stalls at random, or holds off for a long stretch on request.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_idle_en) begin
      out_stall <= ($urandom_range(99) < 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Give up when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one sample, with random gaps before it, and returns once it is taken.
  task automatic send_item(input logic signed [SW-1:0] x, input logic be);
    while (tx_idle_en && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= x;
    block_end_in <= be;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted sample has come out.
  task automatic settle_outputs();
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes all four registers, plus one index that the block must ignore.
  task automatic program_regs(input logic [GAIN_W-1:0] amount, input logic [GAIN_W-1:0] tight,
                              input logic [GAIN_W-1:0] depth, input logic [GAIN_W-1:0] wet);
    cfg_write <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data <= GAIN_W'($urandom);
    @(negedge clk);
    cfg_index <= REG_FILTER_AMOUNT;
    cfg_data <= amount;
    @(negedge clk);
    cfg_index <= REG_TIGHTNESS;
    cfg_data <= tight;
    @(negedge clk);
    cfg_index <= REG_STAGE_DEPTH;
    cfg_data <= depth;
    @(negedge clk);
    cfg_index <= REG_WET_MIX;
    cfg_data <= wet;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SW'(int'($urandom_range(0, 511)) - 256);
      3, 4: return SW'(int'($urandom_range(0, 8191)) - 4096);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_amount();
    case ($urandom_range(7))
      0: return '0;
      1: return ONE_INT;
      2: return GAIN_MAX;
      3: return GAIN_W'($urandom_range(1, 4096));
      default: return GAIN_W'($urandom_range(1, ONE_INT));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_tightness();
    case ($urandom_range(7))
      0: return TIGHT_LIM_INT;
      1: return GAIN_W'(-TIGHT_LIM_INT);
      2: return '0;
      3: return GAIN_W'($urandom);
      default: return GAIN_W'(int'($urandom_range(0, 2 * TIGHT_LIM_INT)) - TIGHT_LIM_INT);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_depth();
    case ($urandom_range(7))
      0: return '0;
      1: return ONE_INT;
      2: return GAIN_MAX;
      3: return GAIN_W'(DEPTH_RESET_INT * $urandom_range(0, 4));
      default: return GAIN_W'($urandom_range(0, ONE_INT));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_wet();
    case ($urandom_range(7))
      0, 3: return ONE_INT;
      1: return '0;
      2: return GAIN_MAX;
      default: return GAIN_W'($urandom_range(0, ONE_INT));
    endcase
  endfunction

  // Directed corners first, then random phases with new settings each time.
  initial begin
    int rand_sent;
    int phase;
    int len;
    rand_sent = 0;
    phase = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: one stage, neutral tightness, fully wet.
    foreach (corner_samples[i]) send_item(corner_samples[i], i == 8);
    settle_outputs();

    // Presets cover the register extremes and the clamps.
    for (int p = 0; p < 5; p++) begin
      program_regs(preset_amount[p], preset_tight[p], preset_depth[p], preset_wet[p]);
      send_item(SAMPLE_MAX, 1'b0);
      send_item(SAMPLE_MIN, 1'b0);
      send_item(SAMPLE_MAX, 1'b1);
      settle_outputs();
    end

    // Random phases; one holds off the result side, one runs without gaps.
    while (rand_sent < RANDOM_ITEMS) begin
      len = $urandom_range(20, 70);
      program_regs(rand_amount(), rand_tightness(), rand_depth(), rand_wet());
      tx_idle_en = (phase != 2);
      rx_idle_en = (phase != 2);
      if (phase == 1) hold_req++;
      repeat (len) send_item(rand_sample(), $urandom_range(7) == 0);
      settle_outputs();
      rand_sent += len;
      phase++;
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
